// ===== src/buddy_page_allocator_top_assert.svh =====
// assertion macros for the buddy page allocator top level
// depends on clk and rst_n being visible where the macros are used
`ifndef BUDDY_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define BPA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BPA_ASSERT_IMPL(lbl, ante, cons, msg)
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/bpa_pkg.sv =====
// shared constants and codes for the buddy page allocator
// no dependencies
`default_nettype none

package bpa_pkg;

    localparam int ORDERS_DEF = 17;
    localparam int PAGES_DEF  = 65536;

    localparam int OP_W     = 2;
    localparam int ORDER_W  = 5;
    localparam int PAGE_W   = 16;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 17;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 17'd65536;

    // free bits are stored in words of this width
    localparam int WORD_W = 32;
    localparam int LOG_W  = $clog2(WORD_W);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_RESERVE = 2'd2,
        OP_INIT    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_BLOCK = 2'd1,
        ST_BAD_ARG  = 2'd2,
        ST_NOT_FREE = 2'd3
    } status_t;

endpackage

`default_nettype wire

// ===== src/buddy_page_allocator_top.sv =====
// buddy page allocator: sequencer around one free-bit word memory
// depends on bpa_pkg and buddy_page_allocator_top_assert.svh
`default_nettype none
`include "buddy_page_allocator_top_assert.svh"

// Usage
// A request transaction (op, order, page_number) is taken at a clock edge with
// start high and busy low. Exactly one result transaction follows: done is high
// for one cycle with status and result_page; the receiver cannot hold it off.
// The user writes total_pages through cfg_we/cfg_wdata only while idle; the block does not enforce this.
// The free set lives in one memory of 32-bit words (2*PAGES bits), with one
// read and one write per cycle; every bit update is a read-modify-write.
// After reset the block clears the memory, one word a cycle, with busy high
// and no result.
// Steps per request:
//   allocate: scan orders upward from the requested one, word by word (order k holds
//     PAGES>>k bits), then split down level by level and clear the final bit
//   free: set the bit, test the buddy, and merge level by level while it is free
//   reserve: probe orders upward for a free block holding the page, then split down
//   initialize: the clearing sweep, then carving into the largest aligned blocks
//   bad arguments are answered straight from idle
// The word scan of allocate sets the worst-case latency.
module buddy_page_allocator_top #(
    parameter int ORDERS = bpa_pkg::ORDERS_DEF,
    parameter int PAGES  = bpa_pkg::PAGES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [bpa_pkg::OP_W-1:0]      op,
    input  wire logic [bpa_pkg::ORDER_W-1:0]   order,
    input  wire logic [bpa_pkg::PAGE_W-1:0]    page_number,
    output logic                               done,
    output logic [bpa_pkg::STATUS_W-1:0]       status,
    output logic [bpa_pkg::PAGE_W-1:0]         result_page,
    input  wire logic                          cfg_we,
    input  wire logic [bpa_pkg::TOTAL_W-1:0]   cfg_wdata
);
    import bpa_pkg::*;

    localparam int NW  = (2 * PAGES + WORD_W - 1) / WORD_W;
    localparam int WAW = (NW > 1) ? $clog2(NW) : 1;
    localparam int IW  = WAW + LOG_W;
    localparam int CW  = $clog2(PAGES + 1);
    localparam int BW  = $clog2(PAGES);
    localparam int KW  = $clog2(ORDERS);
    localparam int LW  = (CW > TOTAL_W) ? CW : TOTAL_W;
    localparam int SW  = ((ORDERS > LW) ? ORDERS : LW) + 1;

    localparam logic [IW:0]     TWO_P   = (IW+1)'(2 * PAGES);
    localparam logic [CW-1:0]   PAGES_V = CW'(PAGES);
    localparam logic [WAW-1:0]  LAST_W  = WAW'(NW - 1);
    localparam logic [KW-1:0]   K_TOP   = KW'(ORDERS - 1);

    typedef enum logic [6:0] {
        S_CLEAR     = 7'b0000001,
        S_IDLE      = 7'b0000010,
        S_SCAN_INIT = 7'b0000100,
        S_SCAN      = 7'b0001000,
        S_RD        = 7'b0010000,
        S_EX        = 7'b0100000,
        S_CARVE     = 7'b1000000
    } state_t;

    typedef enum logic [6:0] {
        M_FREE_SET  = 7'b0000001,
        M_MERGE     = 7'b0000010,
        M_CLR_HI    = 7'b0000100,
        M_SET_PAIR  = 7'b0001000,
        M_CLR_FIN   = 7'b0010000,
        M_RSV_GET   = 7'b0100000,
        M_CARVE_SET = 7'b1000000
    } step_t;

    state_t              state_reg, state_next;
    step_t               step_reg, step_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [KW-1:0]       target_reg, target_next;
    logic [BW-1:0]       b_reg, b_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic                rsv_reg, rsv_next;
    logic                init_reg, init_next;
    logic [WAW-1:0]      clr_reg, clr_next;
    logic [WAW-1:0]      sw_reg, sw_next;
    logic [WAW-1:0]      pw_reg, pw_next;
    logic                pend_reg, pend_next;
    logic [CW-1:0]       rem_reg, rem_next;
    logic [CW-1:0]       addr_reg, addr_next;
    logic [TOTAL_W-1:0]  total_pages_reg;
    logic                done_reg;
    status_t             status_reg;
    logic [PAGE_W-1:0]   result_reg;

    // free-bit memory
    logic [WORD_W-1:0]   mem [NW];
    logic [WORD_W-1:0]   rd_data_reg;
    logic                mem_we;
    logic [WAW-1:0]      mem_wa, rd_a;
    logic [WORD_W-1:0]   mem_wd;

    logic                fin;
    status_t             fin_st;
    logic [PAGE_W-1:0]   fin_pg;

    // block index arithmetic shared by every step
    logic [CW-1:0]       count_k;
    logic [IW:0]         base_w, hi_w;
    logic [IW-1:0]       base_k, hi_i, bit_i, hit_j;
    logic [LOG_W-1:0]    pos, enc;
    logic [WAW-1:0]      word_a, lo_word, hi_word;
    logic [WORD_W-1:0]   bit_m, pair_m, mask_lo, mask_hi, scan_bits;
    logic [BW-1:0]       blk_page, hit_b;
    logic [KW-1:0]       k_dec;
    logic [PAGE_W-1:0]   pg_k;
    logic                pgbit;
    logic [SW-1:0]       lim_s, size_in, pg_s, size_k;
    logic                bad_free, rem_ge;

    assign count_k = PAGES_V >> k_reg;
    assign base_w  = TWO_P - (IW+1)'({count_k, 1'b0});
    assign hi_w    = base_w + (IW+1)'(count_k) - (IW+1)'(1);
    assign base_k  = base_w[IW-1:0];
    assign hi_i    = hi_w[IW-1:0];
    assign bit_i   = base_k + IW'(b_reg);
    assign pos     = bit_i[LOG_W-1:0];
    assign word_a  = bit_i[IW-1:LOG_W];
    assign lo_word = base_k[IW-1:LOG_W];
    assign hi_word = hi_i[IW-1:LOG_W];
    assign bit_m   = WORD_W'(1) << pos;
    assign pair_m  = WORD_W'(3) << {pos[LOG_W-1:1], 1'b0};

    // scan window of the current order within the word under test
    assign mask_lo   = (pw_reg == lo_word) ? ({WORD_W{1'b1}} << base_k[LOG_W-1:0])
                                           : {WORD_W{1'b1}};
    assign mask_hi   = (pw_reg == hi_word) ? ({WORD_W{1'b1}} >> (~hi_i[LOG_W-1:0]))
                                           : {WORD_W{1'b1}};
    assign scan_bits = rd_data_reg & mask_lo & mask_hi;

    // lowest set bit of the scanned word
    always_comb
    begin
        enc = '0;
        for (int t = WORD_W - 1; t >= 0; t--)
        begin
            if (scan_bits[t])
            begin
                enc = LOG_W'(t);
            end
        end
    end

    assign hit_j    = {pw_reg, enc};
    assign hit_b    = BW'(hit_j - base_k);
    assign blk_page = b_reg << k_reg;
    assign k_dec    = k_reg - KW'(1);
    assign pg_k     = page_reg >> k_dec;
    assign pgbit    = pg_k[0];

    // request checks and carve arithmetic
    assign lim_s    = (SW'(total_pages_reg) > SW'(PAGES)) ? SW'(PAGES) : SW'(total_pages_reg);
    assign size_in  = SW'(1) << order;
    assign pg_s     = SW'(page_number);
    assign bad_free = (order >= ORDER_W'(ORDERS)) || ((pg_s & (size_in - SW'(1))) != '0)
                      || (pg_s + size_in > lim_s);
    assign size_k   = SW'(1) << k_reg;
    assign rem_ge   = SW'(rem_reg) >= size_k;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        k_next      = k_reg;
        target_next = target_reg;
        b_next      = b_reg;
        page_next   = page_reg;
        rsv_next    = rsv_reg;
        init_next   = init_reg;
        clr_next    = clr_reg;
        sw_next     = sw_reg;
        pw_next     = pw_reg;
        pend_next   = pend_reg;
        rem_next    = rem_reg;
        addr_next   = addr_reg;
        mem_we      = 1'b0;
        mem_wa      = word_a;
        mem_wd      = rd_data_reg;
        rd_a        = word_a;
        fin         = 1'b0;
        fin_st      = ST_OK;
        fin_pg      = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_wa   = clr_reg;
                mem_wd   = '0;
                clr_next = clr_reg + WAW'(1);
                if (clr_reg == LAST_W)
                begin
                    if (init_reg)
                    begin
                        k_next     = K_TOP;
                        rem_next   = CW'(lim_s);
                        addr_next  = '0;
                        state_next = S_CARVE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (op_t'(op))
                        OP_ALLOC:
                        begin
                            if (order >= ORDER_W'(ORDERS))
                            begin
                                fin    = 1'b1;
                                fin_st = ST_BAD_ARG;
                            end
                            else
                            begin
                                k_next      = KW'(order);
                                target_next = KW'(order);
                                rsv_next    = 1'b0;
                                state_next  = S_SCAN_INIT;
                            end
                        end
                        OP_FREE:
                        begin
                            if (bad_free)
                            begin
                                fin    = 1'b1;
                                fin_st = ST_BAD_ARG;
                            end
                            else
                            begin
                                k_next     = KW'(order);
                                b_next     = BW'(page_number >> order);
                                step_next  = M_FREE_SET;
                                state_next = S_RD;
                            end
                        end
                        OP_RESERVE:
                        begin
                            if (pg_s >= SW'(PAGES))
                            begin
                                fin    = 1'b1;
                                fin_st = ST_NOT_FREE;
                            end
                            else
                            begin
                                k_next      = '0;
                                target_next = '0;
                                b_next      = BW'(page_number);
                                page_next   = page_number;
                                rsv_next    = 1'b1;
                                step_next   = M_RSV_GET;
                                state_next  = S_RD;
                            end
                        end
                        OP_INIT:
                        begin
                            init_next  = 1'b1;
                            clr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN_INIT:
            begin
                if (count_k == '0)
                begin
                    fin        = 1'b1;
                    fin_st     = ST_NO_BLOCK;
                    state_next = S_IDLE;
                end
                else
                begin
                    sw_next    = lo_word;
                    pend_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_a = sw_reg;
                if (pend_reg && scan_bits != '0)
                begin
                    b_next     = hit_b;
                    pend_next  = 1'b0;
                    step_next  = (k_reg > target_reg) ? M_CLR_HI : M_CLR_FIN;
                    state_next = S_RD;
                end
                else if (pend_reg && pw_reg == hi_word)
                begin
                    pend_next = 1'b0;
                    if (k_reg == K_TOP)
                    begin
                        fin        = 1'b1;
                        fin_st     = ST_NO_BLOCK;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + KW'(1);
                        state_next = S_SCAN_INIT;
                    end
                end
                else
                begin
                    pend_next = 1'b1;
                    pw_next   = sw_reg;
                    sw_next   = sw_reg + WAW'(1);
                end
            end
            S_RD:
            begin
                state_next = S_EX;
            end
            S_EX:
            begin
                unique case (step_reg)
                    M_FREE_SET:
                    begin
                        mem_we = 1'b1;
                        mem_wd = rd_data_reg | bit_m;
                        if (k_reg != K_TOP && CW'(b_reg ^ BW'(1)) < count_k)
                        begin
                            step_next  = M_MERGE;
                            state_next = S_RD;
                        end
                        else
                        begin
                            fin        = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    M_MERGE:
                    begin
                        if (rd_data_reg[pos ^ LOG_W'(1)])
                        begin
                            mem_we     = 1'b1;
                            mem_wd     = rd_data_reg & ~pair_m;
                            k_next     = k_reg + KW'(1);
                            b_next     = b_reg >> 1;
                            step_next  = M_FREE_SET;
                            state_next = S_RD;
                        end
                        else
                        begin
                            fin        = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    M_CLR_HI:
                    begin
                        mem_we     = 1'b1;
                        mem_wd     = rd_data_reg & ~bit_m;
                        k_next     = k_dec;
                        b_next     = {b_reg[BW-2:0], rsv_reg & pgbit};
                        step_next  = M_SET_PAIR;
                        state_next = S_RD;
                    end
                    M_SET_PAIR:
                    begin
                        mem_we     = 1'b1;
                        mem_wd     = rd_data_reg | pair_m;
                        step_next  = (k_reg > target_reg) ? M_CLR_HI : M_CLR_FIN;
                        state_next = S_RD;
                    end
                    M_CLR_FIN:
                    begin
                        mem_we     = 1'b1;
                        mem_wd     = rd_data_reg & ~bit_m;
                        fin        = 1'b1;
                        fin_pg     = rsv_reg ? '0 : PAGE_W'(blk_page);
                        state_next = S_IDLE;
                    end
                    M_RSV_GET:
                    begin
                        if (rd_data_reg[pos])
                        begin
                            step_next  = (k_reg == '0) ? M_CLR_FIN : M_CLR_HI;
                            state_next = S_RD;
                        end
                        else if (k_reg == K_TOP || count_k <= CW'(1))
                        begin
                            fin        = 1'b1;
                            fin_st     = ST_NOT_FREE;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            k_next     = k_reg + KW'(1);
                            b_next     = b_reg >> 1;
                            state_next = S_RD;
                        end
                    end
                    M_CARVE_SET:
                    begin
                        mem_we     = 1'b1;
                        mem_wd     = rd_data_reg | bit_m;
                        addr_next  = CW'(SW'(addr_reg) + size_k);
                        rem_next   = CW'(SW'(rem_reg) - size_k);
                        state_next = S_CARVE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_CARVE:
            begin
                if (rem_ge)
                begin
                    b_next     = BW'(addr_reg >> k_reg);
                    step_next  = M_CARVE_SET;
                    state_next = S_RD;
                end
                else if (k_reg == '0)
                begin
                    fin        = 1'b1;
                    init_next  = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next = k_dec;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            step_reg        <= M_FREE_SET;
            init_reg        <= 1'b0;
            clr_reg         <= '0;
            pend_reg        <= 1'b0;
            done_reg        <= 1'b0;
            total_pages_reg <= TOTAL_RESET;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            init_reg  <= init_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
            done_reg  <= fin;
            if (cfg_we)
            begin
                total_pages_reg <= cfg_wdata;
            end
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        target_reg <= target_next;
        b_reg      <= b_next;
        page_reg   <= page_next;
        rsv_reg    <= rsv_next;
        sw_reg     <= sw_next;
        pw_reg     <= pw_next;
        rem_reg    <= rem_next;
        addr_reg   <= addr_next;
        if (fin)
        begin
            status_reg <= fin_st;
            result_reg <= fin_pg;
        end
    end

    // memory port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_a];
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign result_page = result_reg;

    // checks
    `BPA_ASSERT_IMPL(a_done_idle, done, !busy, "result shown while busy")
    `BPA_ASSERT_NEXT(a_init_busy, start && !busy && op == OP_INIT, busy, "init not started")
    `BPA_ASSERT_IMPL(a_fail_zero, done && status != ST_OK, result_page == '0, "page on failure")

endmodule

`default_nettype wire

// ===== dv/buddy_page_allocator_checker.sv =====
// checker for the buddy page allocator: watches request, result and config traffic,
// predicts every result from its own copy of the free set and compares
// depends on bpa_pkg
`timescale 1ns / 100ps

module buddy_page_allocator_checker #(
    parameter int ORDERS = bpa_pkg::ORDERS_DEF,
    parameter int PAGES  = bpa_pkg::PAGES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [bpa_pkg::OP_W-1:0]     op,
    input  logic [bpa_pkg::ORDER_W-1:0]  order,
    input  logic [bpa_pkg::PAGE_W-1:0]   page_number,
    input  logic                         done,
    input  logic [bpa_pkg::STATUS_W-1:0] status,
    input  logic [bpa_pkg::PAGE_W-1:0]   result_page,
    input  logic                         cfg_we,
    input  logic [bpa_pkg::TOTAL_W-1:0]  cfg_wdata,
    output int                           errors,
    output int                           pending
);
    import bpa_pkg::*;

    localparam int NWORDS = (2 * PAGES + WORD_W - 1) / WORD_W;

    typedef struct packed {
        status_t             st;
        logic [PAGE_W-1:0]   pg;
    } answer_t;

    logic [WORD_W-1:0]  free_words [NWORDS];
    logic [TOTAL_W-1:0] managed_pages;
    answer_t            answers_due [$];

    function automatic longint blocks_at(int k);
        return longint'(PAGES) >> k;
    endfunction

    function automatic longint bit_index(int k, longint b);
        return 2 * longint'(PAGES) - 2 * blocks_at(k) + b;
    endfunction

    function automatic bit is_free(int k, longint b);
        longint i;
        i = bit_index(k, b);
        return free_words[i / WORD_W][i % WORD_W];
    endfunction

    function automatic void mark(int k, longint b, bit v);
        longint i;
        i = bit_index(k, b);
        free_words[i / WORD_W][i % WORD_W] = v;
    endfunction

    function automatic longint page_limit();
        return (managed_pages > PAGES) ? longint'(PAGES) : longint'(managed_pages);
    endfunction

    // lowest free block at order k, skipping empty words
    function automatic bit lowest_free(int k, output longint found);
        longint cnt, b, i;
        cnt = blocks_at(k);
        b = 0;
        found = 0;
        while (b < cnt) begin
            i = bit_index(k, b);
            if (i % WORD_W == 0 && b + WORD_W <= cnt && free_words[i / WORD_W] == '0) begin
                b += WORD_W;
                continue;
            end
            if (is_free(k, b)) begin
                found = b;
                return 1'b1;
            end
            b++;
        end
        return 1'b0;
    endfunction

    // carve the managed pages into the largest aligned blocks
    function automatic void carve_free_set();
        longint rem, addr;
        foreach (free_words[w]) free_words[w] = '0;
        rem = page_limit();
        addr = 0;
        for (int k = ORDERS - 1; k >= 0; k--) begin
            while (rem >= (longint'(1) << k)) begin
                mark(k, addr >> k, 1'b1);
                addr += longint'(1) << k;
                rem -= longint'(1) << k;
            end
        end
    endfunction

    function automatic answer_t allocator_answer(op_t code, int ord, longint pg);
        answer_t a;
        int k;
        longint b, sz, bb;
        bit got;
        a.st = ST_OK;
        a.pg = '0;
        case (code)
            OP_ALLOC: begin
                if (ord >= ORDERS) a.st = ST_BAD_ARG;
                else begin
                    got = 1'b0;
                    for (k = ord; k < ORDERS; k++) begin
                        if (lowest_free(k, b)) begin
                            got = 1'b1;
                            break;
                        end
                    end
                    if (!got) a.st = ST_NO_BLOCK;
                    else begin
                        // split down, keep the left half
                        while (k > ord) begin
                            mark(k, b, 1'b0);
                            k--;
                            b *= 2;
                            mark(k, b, 1'b1);
                            mark(k, b + 1, 1'b1);
                        end
                        mark(ord, b, 1'b0);
                        a.pg = PAGE_W'(b << ord);
                    end
                end
            end
            OP_FREE: begin
                sz = longint'(1) << ord;
                if (ord >= ORDERS || (pg & (sz - 1)) != 0 || pg + sz > page_limit())
                    a.st = ST_BAD_ARG;
                else begin
                    // set the bit, then coalesce with the buddy while it is free
                    k = ord;
                    b = pg >> k;
                    mark(k, b, 1'b1);
                    while (k + 1 < ORDERS) begin
                        bb = b ^ 1;
                        if (bb >= blocks_at(k) || !is_free(k, bb)) break;
                        mark(k, b, 1'b0);
                        mark(k, bb, 1'b0);
                        k++;
                        b >>= 1;
                        mark(k, b, 1'b1);
                    end
                end
            end
            OP_RESERVE: begin
                got = 1'b0;
                for (k = 0; k < ORDERS; k++) begin
                    if (is_free(k, pg >> k)) begin
                        got = 1'b1;
                        break;
                    end
                end
                if (!got) a.st = ST_NOT_FREE;
                else begin
                    b = pg >> k;
                    while (k > 0) begin
                        mark(k, b, 1'b0);
                        k--;
                        b *= 2;
                        mark(k, b, 1'b1);
                        mark(k, b + 1, 1'b1);
                        b = pg >> k;
                    end
                    mark(0, pg, 1'b0);
                end
            end
            default: carve_free_set();
        endcase
        return a;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch on %s: got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    assign pending = answers_due.size();

    // watch all three channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            foreach (free_words[w]) free_words[w] = '0;
            managed_pages = TOTAL_RESET;
            answers_due.delete();
            errors = 0;
        end
        else
        begin
            // result transaction first: its request was taken earlier
            if (done)
            begin
                if (answers_due.size() == 0)
                begin
                    $display("%0t result transaction with nothing expected", $time);
                    errors++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (status !== want.st) report_mismatch("status", status, want.st);
                    if (result_page !== want.pg)
                        report_mismatch("result_page", result_page, want.pg);
                end
            end
            if (cfg_we) managed_pages = cfg_wdata;
            if (start && !busy)
                answers_due.push_back(allocator_answer(op_t'(op), int'(order),
                                                       longint'(page_number)));
        end
    end

endmodule

// ===== dv/buddy_page_allocator_top_tb.sv =====
// testbench top for the buddy page allocator: clock, reset, stimulus and verdict
// depends on bpa_pkg, buddy_page_allocator_top and buddy_page_allocator_checker
`timescale 1ns / 100ps

module buddy_page_allocator_top_tb;
    import bpa_pkg::*;

    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam int     PHASES = 8;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     op = OP_ALLOC;
    logic [ORDER_W-1:0]  order = '0;
    logic [PAGE_W-1:0]   page_number = '0;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   result_page;
    logic                cfg_we = 1'b0;
    logic [TOTAL_W-1:0]  cfg_wdata = '0;
    int                  errors, pending;

    logic                took;
    logic                alloc_in_flight;
    logic [ORDER_W-1:0]  order_in_flight;
    longint              cycles;
    int                  items, idle_pct, lim;
    logic [TOTAL_W-1:0]  totals [PHASES] = '{17'd65536, 17'd0, 17'd1, 17'd100,
                                             17'd65535, 17'd131071, 17'd37, 17'd1024};
    // blocks handed out and not yet given back: {order, page}
    logic [ORDER_W+PAGE_W-1:0] held [$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    buddy_page_allocator_top DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op), .order(order),
        .page_number(page_number), .done(done), .status(status),
        .result_page(result_page), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    buddy_page_allocator_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op), .order(order),
        .page_number(page_number), .done(done), .status(status),
        .result_page(result_page), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .errors(errors), .pending(pending)
    );

    // note request acceptance and collect granted blocks
    always @(posedge clk)
    begin
        took <= start && !busy;
        if (start && !busy)
        begin
            alloc_in_flight <= (op == OP_ALLOC);
            order_in_flight <= order;
        end
        if (done && alloc_in_flight && status == ST_OK)
            held.push_back({order_in_flight, result_page});
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[buddy_page_allocator_top] ERROR");
            $finish;
        end
    end

    // one request transaction; start stays high on return unless an idle gap is inserted
    task automatic send(op_t code, int ord, int pg);
        op = code;
        order = ORDER_W'(ord);
        page_number = PAGE_W'(pg);
        start = 1'b1;
        do @(negedge clk); while (!took);
        items++;
        if (code == OP_INIT) held.delete();
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge clk);
        end
    endtask

    task automatic drain();
        start = 1'b0;
        while (pending != 0 || busy) @(negedge clk);
    endtask

    task automatic write_total(logic [TOTAL_W-1:0] v);
        drain();
        cfg_we = 1'b1;
        cfg_wdata = v;
        lim = (v > PAGES_DEF) ? PAGES_DEF : int'(v);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic random_request();
        int r, k, idx;
        logic [ORDER_W+PAGE_W-1:0] blk;
        r = $urandom_range(0, 99);
        if (r < 70 && r >= 40 && held.size() != 0)
        begin
            // give back a granted block
            idx = $urandom_range(0, held.size() - 1);
            blk = held[idx];
            held.delete(idx);
            send(OP_FREE, blk[ORDER_W+PAGE_W-1:PAGE_W], blk[PAGE_W-1:0]);
        end
        else if (r < 70)
        begin
            k = $urandom_range(0, 99);
            if (k < 85) k = $urandom_range(0, 4);
            else if (k < 97) k = $urandom_range(0, 16);
            else k = $urandom_range(17, 31);
            send(OP_ALLOC, k, $urandom);
        end
        else if (r < 82)
            send(OP_RESERVE, $urandom_range(0, 31),
                 ($urandom_range(0, 3) != 0 && lim > 0) ? $urandom_range(0, lim - 1)
                                                        : $urandom);
        else if (r < 90)
            send(OP_FREE, $urandom_range(0, 31), $urandom);
        else if (r < 97)
        begin
            // aligned free inside the managed range, may be a double free
            k = $urandom_range(0, 6);
            send(OP_FREE, k, (lim > 0) ? ($urandom_range(0, lim - 1) >> k) << k : 0);
        end
        else
            send(OP_INIT, $urandom_range(0, 31), $urandom);
    endtask

    initial
    begin
        cycles = 0;
        items = 0;
        idle_pct = 0;
        lim = PAGES_DEF;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed: nothing free before init, then edges of every op
        write_total(17'd65536);
        send(OP_ALLOC, 0, 0);
        send(OP_RESERVE, 0, 5);
        send(OP_INIT, 0, 0);
        send(OP_ALLOC, 16, 0);
        send(OP_ALLOC, 0, 16'hffff);
        send(OP_FREE, 16, 0);
        send(OP_ALLOC, 0, 0);
        send(OP_ALLOC, 17, 0);
        send(OP_ALLOC, 31, 0);
        send(OP_FREE, 17, 0);
        send(OP_FREE, 3, 4);
        send(OP_FREE, 0, 0);
        send(OP_FREE, 0, 0);
        send(OP_RESERVE, 31, 65535);
        send(OP_RESERVE, 0, 65535);
        send(OP_RESERVE, 0, 1234);
        send(OP_FREE, 0, 65535);
        write_total(17'd100);
        send(OP_INIT, 31, 16'hffff);
        send(OP_FREE, 2, 100);
        send(OP_FREE, 2, 96);
        send(OP_ALLOC, 7, 0);
        send(OP_RESERVE, 0, 100);
        send(OP_ALLOC, 16, 0);

        // random phases, each under its own page count
        for (int p = 0; p < PHASES; p++)
        begin
            idle_pct = 0;
            write_total(totals[p]);
            idle_pct = (p < 3) ? 7 : (p < 6) ? 71 : 0;
            send(OP_INIT, 0, 0);
            for (int n = 0; n < 168; n++)
            begin
                random_request();
                if (n == 80 && p == 1) drain();
            end
        end
        drain();
        repeat (50) @(negedge clk);

        $display("ran %0d requests over %0d page counts, including empty, one page and",
                 items, PHASES);
        $display("oversized settings, with bursty, sparse and back-to-back requests");
        if (errors == 0 && pending == 0)
            $display("[buddy_page_allocator_top] OK");
        else
            $display("[buddy_page_allocator_top] ERROR");
        $finish;
    end

endmodule
